@@ hw/rtl/baro_pkg.sv @@
// shared types, constants and curve generation for the barometric altitude block
package baro_pkg;

    localparam int CURVE_ENTRIES_DEF = 256;
    localparam int PRESS_W  = 17;
    localparam int ALT_W    = 25;
    localparam int GAIN_W   = 16;
    localparam int CNT_W    = 8;
    localparam int PHASE_W  = 9;
    localparam int SUM_W    = 34;
    localparam int PREV_W   = 26;
    localparam int MUL_A_W  = 26;
    localparam int MUL_B_W  = 18;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB       = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd9830;
    localparam logic [CNT_W-1:0]  SETTLE_RESET = 8'd20;
    localparam logic [CNT_W-1:0]  CALIB_RESET  = 8'd20;
    localparam logic [16:0]       GAIN_ONE     = 17'd32768;

    localparam logic signed [ALT_W-1:0] ALT_MAX = 25'sd12000000;
    localparam logic signed [ALT_W-1:0] ALT_MIN = -25'sd12000000;

    localparam logic [63:0] Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] EXP_Q30  = 64'd204327700;
    localparam logic [63:0] LN2_Q30  = 64'd744261118;
    localparam logic [63:0] SEA_PA   = 64'd101325;
    localparam logic [63:0] SCALE_MM = 64'd44330000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOK_A,
        ST_LOOK_B,
        ST_INTERP_MUL,
        ST_INTERP_ADD,
        ST_GAIN_MUL,
        ST_KEEP_MUL,
        ST_FILTER,
        ST_OUTPUT,
        ST_CALIB_ADD,
        ST_DIV_START,
        ST_DIV_WAIT
    } state_t;

    typedef enum logic [1:0] {
        MUL_INTERP,
        MUL_GAIN,
        MUL_KEEP
    } mul_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     rd_a;
        logic     rd_b;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     interp_add;
        logic     filt_done;
        logic     calib_add;
        logic     div_start;
        logic     ground_load;
        logic     phase_inc;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic produce;
        logic calib;
        logic at_total;
        logic div_done;
        logic out_free;
    } stat_t;

    function automatic logic [63:0] log2_q30(input logic [63:0] v);
        int n;
        int i;
        logic [63:0] y;
        logic [63:0] fr;
        n = 63;
        fr = '0;
        while (n > 0 && v[n] == 1'b0) n--;
        y = (n >= 30) ? (v >> (n - 30)) : (v << (30 - n));
        for (i = 1; i <= 30; i++) begin
            y = (y * y) >> 30;
            if (y >= (Q30_ONE << 1)) begin
                y = y >> 1;
                fr = fr | (64'd1 << (30 - i));
            end
        end
        return 64'(n) * Q30_ONE + fr;
    endfunction

    function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
        logic [63:0] r;
        case (k)
            1:       r = x;
            2:       r = x / 2;
            3:       r = x / 3;
            4:       r = x / 4;
            5:       r = x / 5;
            6:       r = x / 6;
            7:       r = x / 7;
            8:       r = x / 8;
            9:       r = x / 9;
            10:      r = x / 10;
            11:      r = x / 11;
            12:      r = x / 12;
            13:      r = x / 13;
            14:      r = x / 14;
            default: r = x;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] exp2_frac_q30(input logic [63:0] f);
        logic [63:0] y;
        logic [63:0] acc;
        logic [63:0] term;
        int k;
        y = (f * LN2_Q30) >> 30;
        acc = Q30_ONE;
        term = Q30_ONE;
        for (k = 1; k <= 14; k++) begin
            term = div_small((term * y) >> 30, k);
            acc = acc + term;
        end
        return acc;
    endfunction

    function automatic logic signed [ALT_W-1:0] curve_node(input int k, input int entries);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] q;
        logic [63:0] f;
        logic [63:0] pw;
        logic [63:0] m;
        logic [63:0] absd;
        logic signed [63:0] lg;
        logic signed [63:0] d;
        logic signed [63:0] val;
        logic neg;
        if (k == 0) return ALT_MAX;
        num = 64'(k) * 64'd131072;
        den = 64'(entries) * SEA_PA;
        lg = $signed(log2_q30(num)) - $signed(log2_q30(den));
        neg = lg < 0;
        mag = neg ? 64'(-lg) : 64'(lg);
        prod = (mag * EXP_Q30) >> 30;
        q = prod >> 30;
        f = prod & (Q30_ONE - 64'd1);
        if (neg) begin
            if (f != 0) begin
                q = q + 64'd1;
                f = Q30_ONE - f;
            end
            pw = (q < 63) ? (exp2_frac_q30(f) >> q) : 64'd0;
        end else begin
            pw = (q < 8) ? (exp2_frac_q30(f) << q) : (Q30_ONE << 8);
        end
        d = $signed(Q30_ONE) - $signed(pw);
        absd = (d < 0) ? 64'(-d) : 64'(d);
        m = (absd * SCALE_MM + (Q30_ONE >> 1)) >> 30;
        val = (d < 0) ? -$signed(m) : $signed(m);
        if (val > 64'sd12000000) val = 64'sd12000000;
        if (val < -64'sd12000000) val = -64'sd12000000;
        return ALT_W'(val);
    endfunction

endpackage

@@ hw/rtl/baro_div.sv @@
// restoring divider, signed dividend by unsigned byte, one quotient bit per cycle
module baro_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [baro_pkg::SUM_W-1:0]   dividend,
    input  logic [baro_pkg::CNT_W-1:0]          divisor,
    output logic                                done,
    output logic signed [baro_pkg::SUM_W-1:0]   quotient
);
    localparam int N  = baro_pkg::SUM_W;
    localparam int CW = $clog2(N + 1);

    logic [N-1:0]                 quo_reg, quo_next;
    logic [baro_pkg::CNT_W:0]     rem_reg, rem_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         neg_reg, neg_next;
    logic                         done_reg, done_next;
    logic [baro_pkg::CNT_W:0]     trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {rem_reg[baro_pkg::CNT_W-1:0], quo_reg[N-1]};
        if (start) begin
            neg_next  = dividend[N-1];
            quo_next  = dividend[N-1] ? N'(-dividend) : N'(dividend);
            rem_next  = '0;
            cnt_next  = CW'(N);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule

@@ hw/rtl/baro_ctrl.sv @@
// sequencing state machine for lookup, calibration and filtering
module baro_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  baro_pkg::stat_t      stat,
    output baro_pkg::cmd_t       cmd
);
    baro_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= baro_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = baro_pkg::MUL_INTERP;
        s_ready     = 1'b0;
        case (state_reg)
            baro_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = baro_pkg::ST_LOOK_A;
                end
            end
            baro_pkg::ST_LOOK_A: begin
                cmd.rd_a   = 1'b1;
                state_next = baro_pkg::ST_LOOK_B;
            end
            baro_pkg::ST_LOOK_B: begin
                cmd.rd_b   = 1'b1;
                state_next = baro_pkg::ST_INTERP_MUL;
            end
            baro_pkg::ST_INTERP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = baro_pkg::MUL_INTERP;
                state_next  = baro_pkg::ST_INTERP_ADD;
            end
            baro_pkg::ST_INTERP_ADD: begin
                cmd.interp_add = 1'b1;
                if (stat.produce) begin
                    state_next = baro_pkg::ST_GAIN_MUL;
                end else if (stat.calib) begin
                    state_next = baro_pkg::ST_CALIB_ADD;
                end else if (stat.at_total) begin
                    state_next = baro_pkg::ST_DIV_START;
                end else begin
                    // still settling
                    cmd.phase_inc = 1'b1;
                    state_next    = baro_pkg::ST_IDLE;
                end
            end
            baro_pkg::ST_GAIN_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = baro_pkg::MUL_GAIN;
                state_next  = baro_pkg::ST_KEEP_MUL;
            end
            baro_pkg::ST_KEEP_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = baro_pkg::MUL_KEEP;
                state_next  = baro_pkg::ST_FILTER;
            end
            baro_pkg::ST_FILTER: begin
                cmd.filt_done = 1'b1;
                state_next    = baro_pkg::ST_OUTPUT;
            end
            baro_pkg::ST_OUTPUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = baro_pkg::ST_IDLE;
                end
            end
            baro_pkg::ST_CALIB_ADD: begin
                cmd.calib_add = 1'b1;
                cmd.phase_inc = 1'b1;
                state_next    = baro_pkg::ST_IDLE;
            end
            baro_pkg::ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = baro_pkg::ST_DIV_WAIT;
            end
            baro_pkg::ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    cmd.ground_load = 1'b1;
                    cmd.phase_inc   = 1'b1;
                    state_next      = baro_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = baro_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

@@ hw/rtl/baro_dp.sv @@
// datapath: config registers, curve table, shared multiplier, filter state, output register
module baro_dp #(
    parameter int CURVE_ENTRIES = baro_pkg::CURVE_ENTRIES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  baro_pkg::cmd_t                        cmd,
    output baro_pkg::stat_t                       stat,
    input  logic [baro_pkg::PRESS_W-1:0]          s_pressure_pa,
    input  logic                                  cfg_valid,
    input  logic [baro_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [baro_pkg::GAIN_W-1:0]           cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [baro_pkg::ALT_W-1:0]     m_altitude_mm
);
    localparam int IW = $clog2(CURVE_ENTRIES + 1);
    localparam int SW = baro_pkg::PRESS_W + IW;
    localparam int AW = baro_pkg::ALT_W;
    localparam int PW = baro_pkg::PROD_W;

    typedef logic signed [AW-1:0] curve_arr_t [CURVE_ENTRIES+1];

    function automatic curve_arr_t build_curve();
        curve_arr_t c;
        int k;
        for (k = 0; k <= CURVE_ENTRIES; k++) c[k] = baro_pkg::curve_node(k, CURVE_ENTRIES);
        return c;
    endfunction

    localparam curve_arr_t CURVE = build_curve();

    logic [baro_pkg::GAIN_W-1:0]          gain_reg;
    logic [baro_pkg::CNT_W-1:0]           settle_reg, calib_reg;
    logic [baro_pkg::PHASE_W-1:0]         phase_reg;
    logic signed [baro_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic signed [AW-1:0]                 ground_reg, ground_next;
    logic signed [baro_pkg::PREV_W-1:0]   prev_reg;
    logic [IW-1:0]                        idx_reg;
    logic [baro_pkg::PRESS_W-1:0]         frac_reg;
    logic signed [AW-1:0]                 a_reg, b_reg, alt_reg, alt_next;
    logic signed [PW-1:0]                 prod_reg, acc_reg;
    logic                                 m_valid_reg;
    logic signed [AW-1:0]                 m_alt_reg;

    logic [SW-1:0]                        scaled;
    logic [baro_pkg::PHASE_W-1:0]         total;
    logic [16:0]                          gain_sat;
    logic signed [baro_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [baro_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [PW-1:0]                 mul_p;
    logic signed [PW-1:0]                 interp_rnd;
    logic signed [PW:0]                   filt_sum, filt_rnd;
    logic signed [PW-15:0]                filt_q;
    logic signed [baro_pkg::SUM_W:0]      sum_wide;
    logic signed [baro_pkg::SUM_W-1:0]    div_q;
    logic                                 div_done;
    logic signed [AW+1:0]                 alt_wide;

    function automatic logic filt_q_prev_hi();
        return prev_reg > baro_pkg::PREV_W'(baro_pkg::ALT_MAX);
    endfunction

    function automatic logic filt_q_prev_lo();
        return prev_reg < baro_pkg::PREV_W'(baro_pkg::ALT_MIN);
    endfunction

    assign scaled   = SW'(s_pressure_pa) * SW'(CURVE_ENTRIES);
    assign total    = baro_pkg::PHASE_W'(settle_reg) + baro_pkg::PHASE_W'(calib_reg);
    assign gain_sat = ({1'b0, gain_reg} > baro_pkg::GAIN_ONE) ? baro_pkg::GAIN_ONE
                                                              : {1'b0, gain_reg};

    always_comb begin
        case (cmd.mul_sel)
            baro_pkg::MUL_INTERP: begin
                mul_a = baro_pkg::MUL_A_W'(b_reg) - baro_pkg::MUL_A_W'(a_reg);
                mul_b = {1'b0, frac_reg};
            end
            baro_pkg::MUL_GAIN: begin
                mul_a = baro_pkg::MUL_A_W'(alt_reg) - baro_pkg::MUL_A_W'(ground_reg);
                mul_b = {1'b0, gain_sat};
            end
            baro_pkg::MUL_KEEP: begin
                mul_a = prev_reg;
                mul_b = {1'b0, baro_pkg::GAIN_ONE - gain_sat};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = PW'(mul_a) * PW'(mul_b);

    // truncate toward zero on the interpolation offset
    assign interp_rnd = prod_reg + (prod_reg[PW-1] ? PW'(131071) : PW'(0));
    assign alt_wide   = (AW+2)'(a_reg) + (AW+2)'(interp_rnd >>> 17);
    assign alt_next   = (alt_wide > (AW+2)'(baro_pkg::ALT_MAX)) ? baro_pkg::ALT_MAX :
                        (alt_wide < (AW+2)'(baro_pkg::ALT_MIN)) ? baro_pkg::ALT_MIN :
                        AW'(alt_wide);

    assign filt_sum = (PW+1)'(acc_reg) + (PW+1)'(prod_reg);
    assign filt_rnd = filt_sum + (filt_sum[PW] ? (PW+1)'(32767) : (PW+1)'(0));
    assign filt_q   = (PW-14)'(filt_rnd >>> 15);

    // saturating calibration sum
    always_comb begin
        sum_wide = (baro_pkg::SUM_W+1)'(sum_reg) + (baro_pkg::SUM_W+1)'(alt_reg);
        if (sum_wide[baro_pkg::SUM_W] != sum_wide[baro_pkg::SUM_W-1]) begin
            sum_next = sum_wide[baro_pkg::SUM_W] ? {1'b1, {(baro_pkg::SUM_W-1){1'b0}}}
                                                 : {1'b0, {(baro_pkg::SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[baro_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        if (calib_reg == '0) begin
            ground_next = '0;
        end else if (div_q > baro_pkg::SUM_W'(baro_pkg::ALT_MAX)) begin
            ground_next = baro_pkg::ALT_MAX;
        end else if (div_q < baro_pkg::SUM_W'(baro_pkg::ALT_MIN)) begin
            ground_next = baro_pkg::ALT_MIN;
        end else begin
            ground_next = AW'(div_q);
        end
    end

    baro_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (calib_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= baro_pkg::GAIN_RESET;
            settle_reg  <= baro_pkg::SETTLE_RESET;
            calib_reg   <= baro_pkg::CALIB_RESET;
            phase_reg   <= '0;
            sum_reg     <= '0;
            ground_reg  <= '0;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    baro_pkg::REG_FILTER_GAIN: gain_reg   <= cfg_data;
                    baro_pkg::REG_SETTLE:      settle_reg <= cfg_data[baro_pkg::CNT_W-1:0];
                    baro_pkg::REG_CALIB:       calib_reg  <= cfg_data[baro_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.phase_inc) phase_reg <= phase_reg + 1'b1;
            if (cmd.calib_add) sum_reg <= sum_next;
            if (cmd.ground_load) ground_reg <= ground_next;
            if (cmd.filt_done) prev_reg <= baro_pkg::PREV_W'(filt_q);
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (cmd.load_in) begin
            idx_reg  <= scaled[SW-1:baro_pkg::PRESS_W];
            frac_reg <= scaled[baro_pkg::PRESS_W-1:0];
        end
        if (cmd.rd_a) a_reg <= CURVE[idx_reg];
        if (cmd.rd_b) b_reg <= CURVE[idx_reg + 1'b1];
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
            acc_reg  <= prod_reg;
        end
        if (cmd.interp_add) alt_reg <= alt_next;
        if (cmd.out_load) begin
            m_alt_reg <= (filt_q_prev_hi()) ? baro_pkg::ALT_MAX :
                         (filt_q_prev_lo()) ? baro_pkg::ALT_MIN : AW'(prev_reg);
        end
    end

    assign stat.produce  = phase_reg > total;
    assign stat.calib    = (phase_reg >= baro_pkg::PHASE_W'(settle_reg)) && (phase_reg < total);
    assign stat.at_total = phase_reg == total;
    assign stat.div_done = div_done;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_altitude_mm = m_alt_reg;
endmodule

@@ hw/rtl/baro_altitude_calibrate_filter_top.sv @@
// top level of the barometric altitude block with ground calibration and smoothing
// a filtered beat steps through lookup, interpolation, gain, keep, filter and output states
// a new beat is accepted only in idle, once the previous beat has finished its steps
// the beat that fixes the ground altitude also waits for the bit-serial divider
// the output register lets the next beat enter while a result waits
// synchronous active-low reset restores register defaults and clears phase, sum, ground, filter
module baro_altitude_calibrate_filter_top #(
    parameter int CURVE_ENTRIES = baro_pkg::CURVE_ENTRIES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [baro_pkg::PRESS_W-1:0]          s_pressure_pa,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [baro_pkg::ALT_W-1:0]     m_altitude_mm,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [baro_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [baro_pkg::GAIN_W-1:0]           cfg_data
);
    baro_pkg::cmd_t  cmd;
    baro_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    baro_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    baro_dp #(
        .CURVE_ENTRIES (CURVE_ENTRIES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_pressure_pa (s_pressure_pa),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_altitude_mm (m_altitude_mm)
    );
endmodule
